[rtl/gfm_pkg.sv]
// Shared types and constants of the mirrored-edge Gaussian smoothing filter.
package gfm_pkg;

  localparam int MAX_RADIUS     = 6;
  localparam int RAD_W          = 3;
  localparam int WIN_DEPTH      = 2 * MAX_RADIUS + 1;
  localparam int OFF_W          = $clog2(WIN_DEPTH);
  localparam int SAMPLE_W       = 8;
  localparam int CNT_W          = 10;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 1;
  localparam int IDX_W          = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes; the coefficient registers follow the radius.
  localparam logic [IDX_W-1:0] REG_RADIUS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_CENTER = 3'd1;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [MAX_RADIUS:0] coefs_t;

  // One classified input beat as it travels from the front to the back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                short_frame;
    logic [RAD_W-1:0]    radius;
    logic [RAD_W-1:0]    num_results;
    logic [RAD_W-1:0]    start_lag;
    logic [CNT_W-1:0]    position;
  } gfm_item_t;

endpackage

[rtl/gfm_front.sv]
// Front end: accepts input beats, tracks frame counters and plans the results of each beat.
module gfm_front import gfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic             frame_end_i,
  input  logic [RAD_W-1:0] radius_i,
  output logic             item_valid_o,
  output gfm_item_t        item_o
);

  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] noi_q, noi_d;
  logic [RAD_W-1:0] frame_r_q, frame_r_d;

  logic             accept;
  logic [RAD_W-1:0] r_clamp;
  logic [RAD_W-1:0] r_use;
  logic [CNT_W-1:0] seen_new;
  logic [CNT_W:0]   noi_sum;

  assign accept       = push_i && !full_i;
  assign item_valid_o = accept;

  always_comb begin
    r_clamp  = (radius_i > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_i;
    r_use    = (seen_q == '0) ? r_clamp : frame_r_q;
    seen_new = (seen_q == COUNT_MAX) ? COUNT_MAX : seen_q + 1'b1;

    item_o.sample      = sample_i;
    item_o.last        = frame_end_i;
    item_o.short_frame = 1'b0;
    item_o.radius      = r_use;
    item_o.num_results = '0;
    item_o.start_lag   = r_use;
    item_o.position    = noi_q;

    if (!frame_end_i) begin
      // Mid-frame: one result once the window holds the whole right half.
      item_o.num_results = (seen_new > CNT_W'(r_use)) ? RAD_W'(1) : '0;
    end else if (seen_new < CNT_W'(r_use)) begin
      // Too few samples for the kernel: every sample gets a zero result.
      item_o.short_frame = 1'b1;
      item_o.num_results = seen_new[RAD_W-1:0];
      item_o.start_lag   = '0;
    end else begin
      // End of frame: drain the remaining centers, oldest first.
      item_o.start_lag   = (seen_new > CNT_W'(r_use)) ? r_use
                                                      : RAD_W'(seen_new - 1'b1);
      item_o.num_results = item_o.start_lag + 1'b1;
    end

    noi_sum = {1'b0, noi_q} + (CNT_W+1)'(item_o.num_results);

    seen_d    = seen_q;
    noi_d     = noi_q;
    frame_r_d = frame_r_q;
    if (accept) begin
      frame_r_d = r_use;
      if (frame_end_i) begin
        seen_d = '0;
        noi_d  = '0;
      end else begin
        seen_d = seen_new;
        noi_d  = (noi_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : noi_sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      noi_q     <= '0;
      frame_r_q <= '0;
    end else begin
      seen_q    <= seen_d;
      noi_q     <= noi_d;
      frame_r_q <= frame_r_d;
    end
  end

endmodule

[rtl/gfm_fifo.sv]
// Small queue of classified beats between the front end and the filter engine.
module gfm_fifo import gfm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  input  gfm_item_t wr_item_i,
  output logic      full_o,
  input  logic      rd_take_i,
  output logic      rd_valid_o,
  output gfm_item_t rd_item_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  gfm_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W_Q-1:0] count_q, count_d;
  logic               do_wr, do_rd;

  assign full_o     = (count_q == CNT_W_Q'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_take_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

[rtl/gfm_back.sv]
// Filter engine: owns the sample window and runs one shared multiply-accumulate per result.
module gfm_back import gfm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  gfm_item_t           item_i,
  output logic                item_take_o,
  input  coefs_t              coefs_i,
  input  logic                pop,
  output logic                empty,
  output logic [SAMPLE_W-1:0] smoothed_o,
  output logic [CNT_W-1:0]    position_o,
  output logic                final_result_o,
  output logic                short_frame_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [SAMPLE_W-1:0] window_q [WIN_DEPTH];
  logic [RAD_W-1:0]    r_q, r_d;
  logic [RAD_W-1:0]    cnt_q, cnt_d;
  logic [RAD_W-1:0]    k_q, k_d;
  logic [RAD_W-1:0]    lag_q, lag_d;
  logic                short_q, short_d;
  logic                last_q, last_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [RAD_W-1:0]    j_q, j_d;
  logic                right_q, right_d;
  logic [SAMPLE_W-1:0] acc_q, acc_d;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_smoothed_q;
  logic [CNT_W-1:0]    out_position_q;
  logic                out_final_q;
  logic                out_short_q;

  logic                out_free;
  logic                out_load;
  logic                shift_en;
  logic [OFF_W:0]      off;
  logic [SAMPLE_W-1:0] win_val;
  coef_t               coef;
  logic [SAMPLE_W+COEF_FRAC_BITS-1:0] prod;
  logic [SAMPLE_W-1:0] tap_val;

  assign out_free       = !out_valid_q || pop;
  assign empty          = !out_valid_q;
  assign smoothed_o     = out_smoothed_q;
  assign position_o     = out_position_q;
  assign final_result_o = out_final_q;
  assign short_frame_o  = out_short_q;

  // Window offset of the current tap, with half-sample mirroring at both edges.
  always_comb begin
    if (j_q == '0) begin
      off = (OFF_W+1)'(lag_q);
    end else if (!right_q) begin
      if (CNT_W'(j_q) <= pos_q) begin
        off = (OFF_W+1)'(lag_q) + (OFF_W+1)'(j_q);
      end else begin
        off = (OFF_W+1)'(lag_q) + (OFF_W+1)'({pos_q[RAD_W-1:0], 1'b0}) + 1'b1
              - (OFF_W+1)'(j_q);
      end
    end else if (j_q <= lag_q) begin
      off = (OFF_W+1)'(lag_q - j_q);
    end else begin
      off = (OFF_W+1)'(j_q - lag_q - 1'b1);
    end
    win_val = (off < (OFF_W+1)'(WIN_DEPTH)) ? window_q[off[OFF_W-1:0]] : '0;
    coef    = coefs_i[j_q];
    prod    = win_val * coef[COEF_FRAC_BITS-1:0];
    // A coefficient of one or more passes the sample through unchanged.
    tap_val = coef[COEF_FRAC_BITS] ? win_val : prod[SAMPLE_W+COEF_FRAC_BITS-1:COEF_FRAC_BITS];
  end

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    lag_d       = lag_q;
    short_d     = short_q;
    last_d      = last_q;
    pos_d       = pos_q;
    j_d         = j_q;
    right_d     = right_q;
    acc_d       = acc_q;
    item_take_o = 1'b0;
    shift_en    = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          shift_en    = 1'b1;
          r_d         = item_i.radius;
          cnt_d       = item_i.num_results;
          k_d         = '0;
          lag_d       = item_i.start_lag;
          short_d     = item_i.short_frame;
          last_d      = item_i.last;
          pos_d       = item_i.position;
          j_d         = '0;
          right_d     = 1'b0;
          acc_d       = '0;
          if (item_i.num_results != '0) begin
            state_d = item_i.short_frame ? ST_HOLD : ST_MAC;
          end
        end
      end
      ST_MAC: begin
        acc_d = acc_q + tap_val;
        if (j_q == '0) begin
          if (r_q == '0) begin
            state_d = ST_HOLD;
          end else begin
            j_d     = RAD_W'(1);
            right_d = 1'b0;
          end
        end else if (!right_q) begin
          right_d = 1'b1;
        end else if (j_q == r_q) begin
          state_d = ST_HOLD;
        end else begin
          j_d     = j_q + 1'b1;
          right_d = 1'b0;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (k_q == cnt_q - 1'b1) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            lag_d   = (lag_q == '0) ? '0 : lag_q - 1'b1;
            pos_d   = (pos_q == COUNT_MAX) ? COUNT_MAX : pos_q + 1'b1;
            j_d     = '0;
            right_d = 1'b0;
            acc_d   = '0;
            state_d = short_q ? ST_HOLD : ST_MAC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    lag_q   <= lag_d;
    short_q <= short_d;
    last_q  <= last_d;
    pos_q   <= pos_d;
    j_q     <= j_d;
    right_q <= right_d;
    acc_q   <= acc_d;
    if (out_load) begin
      out_smoothed_q <= short_q ? '0 : acc_q;
      out_position_q <= pos_q;
      out_final_q    <= last_q && (k_q == cnt_q - 1'b1);
      out_short_q    <= short_q;
    end
    if (shift_en) begin
      window_q[0] <= item_i.sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        window_q[i] <= window_q[i-1];
      end
    end
  end

endmodule

[rtl/gaussian_filter_1d_mirror_edges_core.sv]
// Top level of the one-dimensional Gaussian smoothing filter with mirrored frame edges.
//
// Input channel: a sample beat with its frame_end mark is taken when push is high and
// full is low. Result channel: the oldest result sits on the result ports while empty
// is low and leaves when pop is high. Configuration: cfg_index_i selects the radius
// (index 0) or one of the seven coefficients (center, then taps 1 to 6); a write lands
// when cfg_valid_i is high, and cfg_ready_o is always high.
// Each sample beat enters the window in the engine, and for each result it causes, the
// single shared multiply-accumulate visits the center tap and both mirrored neighbors of
// every offset, one tap per cycle, then hands the result over once the output is free.
// The first result of a frame follows its center sample by radius beats; the last radius
// results come out after the frame_end beat. Frames shorter than the radius yield one
// zero result per sample, flagged short_frame.
// Reset clears the frame counters, the queue and the output register and restores
// radius 0 with a unit center coefficient. When the receiver stalls, the finished result
// stays put, the engine finishes the next one and waits, and the input queue of
// QUEUE_DEPTH beats fills until full rises.
module gaussian_filter_1d_mirror_edges_core import gfm_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                frame_end_i,
  output logic                empty,
  input  logic                pop,
  output logic [SAMPLE_W-1:0] smoothed_o,
  output logic [CNT_W-1:0]    position_o,
  output logic                final_result_o,
  output logic                short_frame_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [COEF_W-1:0]   cfg_data_i
);

  // Configuration registers; the user must change them only while idle (not enforced).
  logic [RAD_W-1:0] radius_q;
  coefs_t           coefs_q;

  gfm_item_t front_item;
  logic      front_valid;
  gfm_item_t queue_item;
  logic      queue_valid;
  logic      back_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      // Only the center coefficient starts at unity; all taps start at zero.
      coefs_q  <= coefs_t'(COEF_W'(1) << COEF_FRAC_BITS);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RADIUS: begin
          radius_q <= cfg_data_i[RAD_W-1:0];
        end
        default: begin
          // Indexes from the center coefficient on map onto the coefficient array.
          coefs_q[cfg_index_i - REG_COEF_CENTER] <= cfg_data_i;
        end
      endcase
    end
  end

  // The front counts samples and decides how many results each beat releases.
  gfm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .sample_i     (sample_i),
    .frame_end_i  (frame_end_i),
    .radius_i     (radius_q),
    .item_valid_o (front_valid),
    .item_o       (front_item)
  );

  gfm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_item_i  (front_item),
    .full_o     (full),
    .rd_take_i  (back_take),
    .rd_valid_o (queue_valid),
    .rd_item_o  (queue_item)
  );

  // The back shifts the window and computes the planned results one tap at a time.
  gfm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .item_take_o    (back_take),
    .coefs_i        (coefs_q),
    .pop            (pop),
    .empty          (empty),
    .smoothed_o     (smoothed_o),
    .position_o     (position_o),
    .final_result_o (final_result_o),
    .short_frame_o  (short_frame_o)
  );

endmodule

[rtl/gfm_checker.sv]
// Port-level checker for the smoothing filter and its bind to the top level.
module gfm_checker import gfm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [SAMPLE_W-1:0] smoothed_o,
  input logic [CNT_W-1:0]    position_o,
  input logic                final_result_o,
  input logic                short_frame_o
);

  // Reset leaves nothing waiting on either side.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("queue not idle after reset");

  // A waiting result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(smoothed_o) && $stable(position_o)
                          && $stable(final_result_o) && $stable(short_frame_o)))
    else $error("result changed while stalled");

  // Short frames carry forced zero values.
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && short_frame_o) |-> (smoothed_o == '0))
    else $error("short frame result not zero");

  // A short frame holds fewer samples than the largest radius.
  a_short_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && short_frame_o) |-> (position_o < CNT_W'(MAX_RADIUS)))
    else $error("short frame result position out of range");

endmodule

bind gaussian_filter_1d_mirror_edges_core gfm_checker u_gfm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .smoothed_o     (smoothed_o),
  .position_o     (position_o),
  .final_result_o (final_result_o),
  .short_frame_o  (short_frame_o)
);

[sim/gaussian_filter_1d_mirror_edges_core_tb.sv]
// Self-checking testbench for the mirrored-edge Gaussian smoothing filter core.
module gaussian_filter_1d_mirror_edges_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfm_pkg::*;

  localparam int    CLK_PERIOD   = 20;
  localparam int    RESET_CYCLES = 11;
  // The random part stops once this many sample beats have gone in.
  localparam int    RANDOM_BEATS = 350;
  // The closing frame is several windows long, so mid-frame results dominate it.
  localparam int    LONG_FRAME   = 40;
  // No-result beats can still be queued when the last result leaves.
  localparam int    IDLE_SETTLE  = 40;
  // The frame_end beat of a radius-6 frame releases seven results.
  localparam int    END_SETTLE   = 120;
  localparam int    HOLD_OFF     = 300;
  localparam int    LIMIT_CYCLES = 1000000;
  localparam coef_t COEF_ONE     = coef_t'(1) << COEF_FRAC_BITS;
  localparam int    NUM_REGS     = MAX_RADIUS + 2;

  // Stall patterns of the result side.
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_mode_e;

  // One result beat as it leaves the core.
  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic [CNT_W-1:0]    position;
    logic                last_of_frame;
    logic                short_frame;
  } smoothed_beat_t;

  // Tracks the filter's register copy and frame state, predicts the results of every
  // accepted sample beat, and checks the result beats against them in order.
  class smoothing_tracker;
    logic [RAD_W-1:0]    radius_reg;
    coefs_t              coefs;
    logic [SAMPLE_W-1:0] window [WIN_DEPTH];
    int                  seen;
    int                  out_idx;
    int                  frame_r;
    smoothed_beat_t      due_results[$];
    int                  mismatches;
    int                  checked;
    int                  beats;
    int                  frames;
    int                  short_frames;

    function new();
      radius_reg = '0;
      coefs      = '0;
      coefs[0]   = COEF_ONE;
      foreach (window[k]) window[k] = '0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, coef_t data);
      if (idx == REG_RADIUS) radius_reg = data[RAD_W-1:0];
      else coefs[idx - REG_COEF_CENTER] = data;
    endfunction

    // One truncated product; a coefficient above unity counts as exactly unity.
    function logic [SAMPLE_W-1:0] weigh(logic [SAMPLE_W-1:0] x, coef_t c);
      logic [SAMPLE_W+COEF_W-1:0] prod;
      coef_t                      cc;
      cc   = (c > COEF_ONE) ? COEF_ONE : c;
      prod = x * cc;
      return prod[COEF_FRAC_BITS +: SAMPLE_W];
    endfunction

    // Filters the sample lag beats behind the newest one; idx is the frame index of that sample.
    // Neighbors beyond either frame edge are reflected about the half-sample point.
    function logic [SAMPLE_W-1:0] mirror_convolve(int lag, int idx, int r);
      logic [SAMPLE_W-1:0] acc;
      int                  lo;
      int                  ro;
      acc = weigh(window[lag], coefs[0]);
      for (int j = 1; j <= r; j++) begin
        lo  = (j <= idx) ? lag + j : lag + 2 * idx + 1 - j;
        ro  = (j <= lag) ? lag - j : j - lag - 1;
        acc += weigh(window[lo], coefs[j]) + weigh(window[ro], coefs[j]);
      end
      return acc;
    endfunction

    function void add_result(logic [SAMPLE_W-1:0] v, logic fin, logic sh);
      due_results.push_back('{v, CNT_W'(out_idx), fin, sh});
      if (out_idx < COUNT_MAX) out_idx++;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic last);
      int lag;
      if (seen == 0) frame_r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = s;
      if (seen < COUNT_MAX) seen++;
      beats++;
      if (!last) begin
        if (seen > frame_r) begin
          add_result(mirror_convolve(frame_r, out_idx, frame_r), 1'b0, 1'b0);
        end
        return;
      end
      frames++;
      if (seen < frame_r) begin
        short_frames++;
        for (int p = 0; p < seen; p++) add_result('0, p + 1 == seen, 1'b1);
      end else begin
        // The results still owed drain here, the center moving to the newest sample.
        lag = (seen > frame_r) ? frame_r : seen - 1;
        for (; lag >= 0; lag--) begin
          add_result(mirror_convolve(lag, out_idx, frame_r), lag == 0, 1'b0);
        end
      end
      seen    = 0;
      out_idx = 0;
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] v, logic [CNT_W-1:0] pos, logic fin,
                               logic sh);
      smoothed_beat_t got;
      smoothed_beat_t want;
      got = '{v, pos, fin, sh};
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: smoothed=%0d position=%0d last=%0b short=%0b",
                 $time, v, pos, fin, sh);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        $display("%0t: expected smoothed=%0d position=%0d last=%0b short=%0b", $time,
                 want.smoothed, want.position, want.last_of_frame, want.short_frame);
        $display("%0t:   actual smoothed=%0d position=%0d last=%0b short=%0b", $time,
                 v, pos, fin, sh);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                frame_end_i = 1'b0;
  logic                empty;
  logic                pop         = 1'b0;
  logic [SAMPLE_W-1:0] smoothed_o;
  logic [CNT_W-1:0]    position_o;
  logic                final_result_o;
  logic                short_frame_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i = '0;
  logic [COEF_W-1:0]   cfg_data_i  = '0;

  smoothing_tracker filter_tracker = new();

  // Beats left in the current sender burst, and cycles left of a requested result hold-off.
  int burst_left  = 0;
  int hold_cycles = 0;

  gaussian_filter_1d_mirror_edges_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_i       (sample_i),
    .frame_end_i    (frame_end_i),
    .empty          (empty),
    .pop            (pop),
    .smoothed_o     (smoothed_o),
    .position_o     (position_o),
    .final_result_o (final_result_o),
    .short_frame_o  (short_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin : clock_gen
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Every result beat taken at a rising edge is checked against the oldest prediction.
  // Outputs are read right after the edge, before the core's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      filter_tracker.check_result(smoothed_o, position_o, final_result_o, short_frame_o);
    end
  end

  // The result side switches between stall patterns of random length. A hold-off request
  // from the stimulus keeps pop low for its whole length so that the input backs up.
  initial begin : receiver
    rx_mode_e mode;
    int       left;
    int       tick;
    mode = RX_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          left = $urandom_range(16, 160);
        end
        left--;
        tick++;
        case (mode)
          RX_ALWAYS: pop <= 1'b1;
          RX_COIN:   pop <= 1'($urandom_range(0, 1));
          default:   pop <= (tick % 4 == 0);
        endcase
      end
    end
  end

  // Offers one sample beat and returns once it is taken. Between bursts the sender drops
  // push for a random gap; some bursts are long enough to keep the input busy for a while.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    push        <= 1'b1;
    sample_i    <= value;
    frame_end_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    filter_tracker.note_sample(value, last);
  endtask

  // Writes the registers picked by mask: bit 0 the radius, bit k+1 coefficient k.
  // The upper data bits of a radius write are random, since only the low bits count.
  task automatic configure(input logic [NUM_REGS-1:0] mask, input logic [RAD_W-1:0] radius,
                           input coefs_t c);
    coef_t            data;
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (mask[k]) begin
        if (k == 0) begin
          idx                 = REG_RADIUS;
          data                = coef_t'($urandom);
          data[RAD_W-1:0]     = radius;
        end else begin
          idx  = REG_COEF_CENTER + IDX_W'(k - 1);
          data = c[k-1];
        end
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx;
        cfg_data_i  <= data;
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        filter_tracker.write_reg(idx, data);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering input and waits until every predicted result beat has been taken,
  // then lets extra cycles pass for beats that cause no result.
  task automatic settle(input int extra);
    push <= 1'b0;
    @(posedge clk_i);
    while (filter_tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic coef_t random_coef();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COEF_ONE;
      2:       return coef_t'($urandom_range(int'(COEF_ONE) + 1, 2 * int'(COEF_ONE) - 1));
      default: return coef_t'($urandom_range(0, int'(COEF_ONE) - 1));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int len, input logic closed);
    for (int k = 0; k < len; k++) send_sample(random_sample(), closed && k == len - 1);
  endtask

  initial begin : stimulus
    coefs_t               c;
    logic [NUM_REGS-1:0]  mask;
    logic [RAD_W-1:0]     radius;
    int                   phase;
    int                   nframes;
    int                   len;
    int                   r_next;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: radius 0 and a unit center tap pass the samples straight through.
    send_sample(8'd255, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd128, 1'b1);
    settle(IDLE_SETTLE);

    // Radius 7 clamps to 6, a center coefficient past unity acts as unity, and the
    // taps sit at exactly unity. Three samples make a short frame; six is just enough.
    foreach (c[k]) c[k] = COEF_ONE;
    c[0] = '1;
    configure('1, 3'd7, c);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    for (int k = 0; k < 6; k++) send_sample((k % 2 == 0) ? 8'h55 : 8'hAA, k == 5);
    settle(IDLE_SETTLE);

    // A radius change in the middle of a frame waits for the next frame, while a new
    // coefficient applies at once. The following one-sample frame is then short.
    c    = '0;
    c[0] = coef_t'(17'h08000);
    c[1] = coef_t'(17'h04000);
    c[2] = coef_t'(17'h02000);
    configure('1, 3'd2, c);
    send_sample(8'd10, 1'b0);
    send_sample(8'd200, 1'b0);
    send_sample(8'd30, 1'b0);
    send_sample(8'd250, 1'b0);
    settle(IDLE_SETTLE);
    c[2] = coef_t'(17'h06000);
    configure(NUM_REGS'(8'b0000_1001), 3'd5, c);
    send_sample(8'd1, 1'b0);
    send_sample(8'd2, 1'b0);
    send_sample(8'd3, 1'b1);
    send_sample(8'd99, 1'b1);
    settle(IDLE_SETTLE);

    // All coefficients zero: every result is zero.
    configure('1, 3'd0, '0);
    send_sample(8'd77, 1'b0);
    send_sample(8'd99, 1'b1);

    // Random phases: each writes a random set of registers while idle, then sends a few
    // frames of mixed length. Phase 1 holds the result side off for a long stretch so
    // that the input fills and full rises. Some phases leave their last frame open.
    phase = 0;
    while (filter_tracker.beats < RANDOM_BEATS) begin
      settle(IDLE_SETTLE);
      foreach (c[k]) c[k] = random_coef();
      mask   = (phase == 0) ? '1 : NUM_REGS'($urandom_range(1, 255));
      radius = RAD_W'($urandom_range(0, 7));
      configure(mask, radius, c);
      if (phase == 1) hold_cycles = HOLD_OFF;
      r_next  = (filter_tracker.radius_reg > MAX_RADIUS) ? MAX_RADIUS
                                                         : filter_tracker.radius_reg;
      nframes = $urandom_range(2, 6);
      for (int f = 0; f < nframes; f++) begin
        case ($urandom_range(0, 7))
          0:       len = (r_next > 1) ? $urandom_range(1, r_next - 1) : 1;
          1:       len = $urandom_range(13, 40);
          default: len = $urandom_range(1, 14);
        endcase
        send_frame(len, f < nframes - 1 || $urandom_range(0, 3) != 0);
      end
      phase++;
    end

    // One longer frame with a fresh radius closes the run.
    settle(IDLE_SETTLE);
    configure(NUM_REGS'(1), RAD_W'($urandom_range(1, 7)), c);
    send_frame(LONG_FRAME, 1'b1);

    settle(END_SETTLE);
    if (filter_tracker.due_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               filter_tracker.due_results.size());
    end
    $display("Covered %0d sample beats in %0d closed frames (%0d short) over %0d phases.",
             filter_tracker.beats, filter_tracker.frames, filter_tracker.short_frames, phase);
    $display("Checked %0d results with radii 0 to 7 and coefficients from zero past unity.",
             filter_tracker.checked);
    if (filter_tracker.mismatches == 0 && filter_tracker.due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results still expected.", filter_tracker.due_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[gaussian_filter_1d_mirror_edges_core.f]
rtl/gfm_pkg.sv
rtl/gfm_front.sv
rtl/gfm_fifo.sv
rtl/gfm_back.sv
rtl/gaussian_filter_1d_mirror_edges_core.sv
rtl/gfm_checker.sv
sim/gaussian_filter_1d_mirror_edges_core_tb.sv
